>>> rtl/htc_pkg.sv
// shared widths, types and fixed-point constants for the humidity and temperature conversion
// no dependencies
package htc_pkg;

    localparam int unsigned RH_W   = 12;
    localparam int unsigned TICK_W = 14;
    localparam int unsigned TEMP_W = 15;
    localparam int unsigned HUM_W  = 14;
    localparam int unsigned NUM_W  = 41;
    localparam int unsigned PIPE_DEPTH = 7;

    typedef logic        [RH_W-1:0]   t_rh;
    typedef logic        [TICK_W-1:0] t_ticks;
    typedef logic signed [TEMP_W-1:0] t_temp;
    typedef logic        [HUM_W-1:0]  t_hum;
    typedef logic signed [NUM_W-1:0]  t_num;

    // numerator is divided by five throughout, so the quotient divisor is 2e7
    localparam logic        [38:0]      LIN_K    = 39'd73400000;
    localparam logic        [35:0]      SQ_K     = 36'd3191;
    localparam t_num                    NUM_OFS  = 41'sd4093600000;
    localparam t_num                    TC_K     = 41'sd200;
    localparam logic signed [14:0]      T_REF    = 15'sd6470;
    localparam t_temp                   T_OFS    = 15'sd3970;
    localparam logic        [15:0]      FAC_BASE = 16'd1000;

    // floor(m / 2e7) = floor((m >> 7) / 156250), reciprocal with one correction step
    localparam logic        [61:0]      RECIP    = 62'd1801439850;
    localparam logic        [31:0]      DIV_K    = 32'd156250;
    localparam logic        [32:0]      DIV_K33  = 33'd156250;
    localparam t_num                    NUM_LO   = 41'sd200000000;
    localparam t_num                    NUM_HI   = 41'sd200000000000;
    localparam t_hum                    HUM_MIN  = 14'd10;
    localparam t_hum                    HUM_MAX  = 14'd10000;

endpackage

>>> rtl/htc_poly.sv
// three-stage polynomial datapath giving the scaled humidity numerator
// depends on htc_pkg
module htc_poly
    import htc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_en,
    input  t_rh    i_rh,
    input  t_ticks i_t,
    output t_num   o_num
);

    logic        [23:0] r_sq;
    logic        [38:0] r_lin;
    logic signed [14:0] r_dt;
    logic        [15:0] r_fac;

    logic        [35:0] r_sqk;
    logic signed [29:0] r_de;
    logic        [38:0] r_lin2;

    t_num               r_num;

    logic signed [29:0] n_de;
    t_num               n_num;

    always_comb begin
        n_de  = 30'(r_dt) * 30'($signed({1'b0, r_fac}));
        n_num = 41'($signed({1'b0, r_lin2})) - 41'($signed({1'b0, r_sqk}))
              - NUM_OFS + 41'(r_de) * TC_K;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 1
            r_sq   <= {12'b0, i_rh} * {12'b0, i_rh};
            r_lin  <= 39'(i_rh) * LIN_K;
            r_dt   <= $signed({1'b0, i_t}) - T_REF;
            r_fac  <= FAC_BASE + {1'b0, i_rh, 3'b000};
            // stage 2
            r_sqk  <= 36'(r_sq) * SQ_K;
            r_de   <= n_de;
            r_lin2 <= r_lin;
            // stage 3
            r_num  <= n_num;
        end
    end

    assign o_num = r_num;

endmodule

>>> rtl/htc_div.sv
// three-stage constant division by reciprocal with correction and clamp
// depends on htc_pkg
module htc_div
    import htc_pkg::*;
(
    input  logic i_clk,
    input  logic i_en,
    input  t_num i_num,
    output t_hum o_hum
);

    logic [61:0] r_prod;
    logic [30:0] r_x;
    logic        r_lo;
    logic        r_hi;

    t_hum        r_qe;
    logic [31:0] r_qm;
    logic [30:0] r_x2;
    logic        r_lo2;
    logic        r_hi2;

    t_hum        r_hum;

    logic [32:0] n_diff;
    t_hum        n_q;
    t_hum        n_hum;

    always_comb begin
        n_diff = {2'b00, r_x2} - {1'b0, r_qm};
        n_q    = r_qe + 14'(n_diff >= DIV_K33);
        if (r_lo2) begin
            n_hum = HUM_MIN;
        end else if (r_hi2) begin
            n_hum = HUM_MAX;
        end else begin
            n_hum = n_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 4
            r_prod <= 62'(i_num[37:7]) * RECIP;
            r_x    <= i_num[37:7];
            r_lo   <= i_num < NUM_LO;
            r_hi   <= i_num >= NUM_HI;
            // stage 5
            r_qe   <= r_prod[61:48];
            r_qm   <= 32'(r_prod[61:48]) * DIV_K;
            r_x2   <= r_x;
            r_lo2  <= r_lo;
            r_hi2  <= r_hi;
            // stage 6
            r_hum  <= n_hum;
        end
    end

    assign o_hum = r_hum;

endmodule

>>> rtl/humidity_temperature_conversion.sv
// top level of the humidity and temperature conversion pipeline
// depends on htc_pkg, htc_poly and htc_div
// Converts one raw reading pair per clock into temperature in hundredths of a degree and
// compensated relative humidity in hundredths of a percent, clamped to 10..10000. The pipeline
// has seven register stages: the input register, three polynomial stages and three division
// stages. The result is valid once the request has passed through all of them. A new request
// is taken every cycle unless a result waits at the output, in which case the whole pipeline
// holds.
module humidity_temperature_conversion
    import htc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,  // humidity_ticks[11:0], temperature_ticks[25:12], zero
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata   // temperature_centi[14:0], humidity_centi[28:15], zero
);

    logic                  n_en;
    logic [PIPE_DEPTH-1:0] r_vld;
    t_rh                   r_rh;
    t_ticks                r_t;
    t_temp                 r_tc [PIPE_DEPTH];
    t_num                  w_num;
    t_hum                  w_hum;

    assign n_en = ~r_vld[PIPE_DEPTH-1] | i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (n_en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_s_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_rh    <= i_s_tdata[11:0];
            r_t     <= i_s_tdata[25:12];
            r_tc[0] <= $signed({1'b0, i_s_tdata[25:12]}) - T_OFS;
            for (int i = 1; i < PIPE_DEPTH; i++) begin
                r_tc[i] <= r_tc[i-1];
            end
        end
    end

    htc_poly u_poly (
        .i_clk (i_clk),
        .i_en  (n_en),
        .i_rh  (r_rh),
        .i_t   (r_t),
        .o_num (w_num)
    );

    htc_div u_div (
        .i_clk (i_clk),
        .i_en  (n_en),
        .i_num (w_num),
        .o_hum (w_hum)
    );

    assign o_s_tready = n_en;
    assign o_m_tvalid = r_vld[PIPE_DEPTH-1];
    assign o_m_tdata  = {3'b000, w_hum, r_tc[PIPE_DEPTH-1]};

endmodule

>>> rtl/htc_checker.sv
// port-level checks for the humidity and temperature conversion, bound to the top level
// depends on humidity_temperature_conversion
module htc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [31:0] i_s_tdata,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata
);

    // a waiting result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    // pipeline moves whenever the output slot is free or drained
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == (!o_m_tvalid || i_m_tready))
        else $error("ready does not follow output stall");

    a_hum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[28:15] >= 14'd10) && (o_m_tdata[28:15] <= 14'd10000))
        else $error("humidity out of clamp range");

    a_temp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ($signed(o_m_tdata[14:0]) >= -15'sd3970)
                    && ($signed(o_m_tdata[14:0]) <= 15'sd12413))
        else $error("temperature out of range");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind humidity_temperature_conversion htc_checker u_htc_checker (.*);
